// ----- rtl/core/cbe_pkg.sv -----
// Shared types and constants of the CBOR item head encoder.
package cbe_pkg;

  typedef enum logic [3:0] {
    CMD_UINT    = 4'd0,
    CMD_SINT    = 4'd1,
    CMD_BYTES   = 4'd2,
    CMD_TEXT    = 4'd3,
    CMD_ARRAY   = 4'd4,
    CMD_MAP     = 4'd5,
    CMD_TAG     = 4'd6,
    CMD_SIMPLE  = 4'd7,
    CMD_BOOL    = 4'd8,
    CMD_NULL    = 4'd9,
    CMD_UNDEF   = 4'd10,
    CMD_PAYLOAD = 4'd11
  } cmd_t;

  localparam logic [2:0] MAJ_UINT = 3'd0;
  localparam logic [2:0] MAJ_NINT = 3'd1;

  // Additional info codes that announce 1, 2, 4 or 8 argument bytes.
  localparam logic [4:0] AI_ARG1 = 5'd24;
  localparam logic [4:0] AI_ARG2 = 5'd25;
  localparam logic [4:0] AI_ARG4 = 5'd26;
  localparam logic [4:0] AI_ARG8 = 5'd27;

  localparam logic [7:0] BYTE_FALSE = 8'hf4;
  localparam logic [7:0] BYTE_TRUE  = 8'hf5;
  localparam logic [7:0] BYTE_NULL  = 8'hf6;
  localparam logic [7:0] BYTE_UNDEF = 8'hf7;

  localparam int unsigned MAX_ARG_BYTES = 8;

  // One classified item: the initial byte, the argument bytes left-aligned
  // so that the next one to send sits in the top byte, and their count.
  typedef struct packed {
    logic [7:0]  lead;
    logic [63:0] arg;
    logic [3:0]  nbytes;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } push_t;

endpackage

// ----- rtl/core/cbe_front.sv -----
// Front end: classifies a command into an initial byte and argument bytes.
module cbe_front (
  input  logic        in_push,
  input  logic [3:0]  in_command,
  input  logic [63:0] in_value,
  output cbe_pkg::push_t wr
);

  logic [2:0]  major;
  logic [63:0] arg;
  logic        known;
  logic        fixed;
  logic [7:0]  fixed_byte;

  always_comb begin
    major      = cbe_pkg::MAJ_UINT;
    arg        = in_value;
    known      = 1'b1;
    fixed      = 1'b0;
    fixed_byte = in_value[7:0];
    unique case (cbe_pkg::cmd_t'(in_command))
      cbe_pkg::CMD_UINT: begin
        major = cbe_pkg::MAJ_UINT;
      end
      cbe_pkg::CMD_SINT: begin
        if (in_value[63]) begin
          major = cbe_pkg::MAJ_NINT;
          arg   = ~in_value;
        end
      end
      cbe_pkg::CMD_BYTES, cbe_pkg::CMD_TEXT, cbe_pkg::CMD_ARRAY,
      cbe_pkg::CMD_MAP, cbe_pkg::CMD_TAG, cbe_pkg::CMD_SIMPLE: begin
        major = in_command[2:0];
      end
      cbe_pkg::CMD_BOOL: begin
        fixed      = 1'b1;
        fixed_byte = in_value[0] ? cbe_pkg::BYTE_TRUE : cbe_pkg::BYTE_FALSE;
      end
      cbe_pkg::CMD_NULL: begin
        fixed      = 1'b1;
        fixed_byte = cbe_pkg::BYTE_NULL;
      end
      cbe_pkg::CMD_UNDEF: begin
        fixed      = 1'b1;
        fixed_byte = cbe_pkg::BYTE_UNDEF;
      end
      cbe_pkg::CMD_PAYLOAD: begin
        fixed      = 1'b1;
        fixed_byte = in_value[7:0];
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr.valid       = in_push && known;
    wr.desc.lead   = fixed_byte;
    wr.desc.arg    = arg;
    wr.desc.nbytes = 4'd0;
    if (!fixed) begin
      priority if (arg[63:5] == 59'd0 && !(arg[4] && arg[3])) begin
        wr.desc.lead = {major, arg[4:0]};
      end else if (arg[63:8] == 56'd0) begin
        wr.desc.lead   = {major, cbe_pkg::AI_ARG1};
        wr.desc.arg    = {arg[7:0], 56'd0};
        wr.desc.nbytes = 4'd1;
      end else if (arg[63:16] == 48'd0) begin
        wr.desc.lead   = {major, cbe_pkg::AI_ARG2};
        wr.desc.arg    = {arg[15:0], 48'd0};
        wr.desc.nbytes = 4'd2;
      end else if (arg[63:32] == 32'd0) begin
        wr.desc.lead   = {major, cbe_pkg::AI_ARG4};
        wr.desc.arg    = {arg[31:0], 32'd0};
        wr.desc.nbytes = 4'd4;
      end else begin
        wr.desc.lead   = {major, cbe_pkg::AI_ARG8};
        wr.desc.nbytes = 4'd8;
      end
    end
  end

endmodule

// ----- rtl/core/cbe_queue.sv -----
// Short descriptor queue between the front end and the serializer.
module cbe_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cbe_pkg::push_t wr,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output cbe_pkg::desc_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cbe_pkg::desc_t slot_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = wr.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr.desc;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count exceeds its depth");

  a_idle_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !wr.valid) |=> empty)
    else $error("queue filled without a push");
`endif

endmodule

// ----- rtl/core/cbe_back.sv -----
// Serializer: sends the initial byte, then the argument bytes, one a cycle while the result side pops.
module cbe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  cbe_pkg::desc_t q_head,
  output logic           q_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output logic [7:0]     out_byte,
  output logic           out_last
);

  logic [63:0] sh_r, sh_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic        valid_r, valid_nxt;
  logic        adv;

  assign adv   = !valid_r || out_pop;
  assign q_pop = adv && (rem_r == 4'd0) && !q_empty;

  always_comb begin
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    valid_nxt = valid_r;
    if (adv) begin
      if (rem_r != 4'd0) begin
        byte_nxt  = sh_r[63:56];
        last_nxt  = (rem_r == 4'd1);
        sh_nxt    = {sh_r[55:0], 8'd0};
        rem_nxt   = rem_r - 4'd1;
        valid_nxt = 1'b1;
      end else if (!q_empty) begin
        byte_nxt  = q_head.lead;
        last_nxt  = (q_head.nbytes == 4'd0);
        sh_nxt    = q_head.arg;
        rem_nxt   = q_head.nbytes;
        valid_nxt = 1'b1;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= 4'd0;
      valid_r <= 1'b0;
    end else begin
      rem_r   <= rem_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_empty = !valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 4'(cbe_pkg::MAX_ARG_BYTES))
    else $error("argument byte count out of range");

  a_pending_means_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != 4'd0) |-> (valid_r && !last_r))
    else $error("argument bytes pending after a final byte");
`endif

endmodule

// ----- rtl/core/cbor_head_encoder.sv -----
// Top level of the CBOR item head encoder.
//
//   Channel  Ports                          Direction  Transaction
//   -------  -----------------------------  ---------  -------------------------------
//   input    in_push, in_full,              in         push && !full takes one command
//            in_command, in_value
//   result   out_empty, out_pop,            out        pop && !empty takes one byte
//            out_byte, out_last
//
// A command that encodes to one byte (a small argument, bool, null, undefined
// or a payload byte) needs no argument bytes, so such commands flow at one per cycle while the result side pops.
// A command with k argument bytes (k = 1, 2, 4 or 8) occupies the serializer until
// all 1 + k bytes are sent, since the output register sends one byte a cycle while the result side pops.
// Reset is synchronous and active low; it empties the queue and the output.
// The front end keeps accepting while the queue has room, so a stalled result
// side fills the queue before in_full rises.
module cbor_head_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [3:0]  in_command,
  input  logic [63:0] in_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  // The front end turns each command into a descriptor: the initial byte,
  // the argument bytes aligned to the top of a 64-bit word, and how many
  // argument bytes follow. Unused command codes are accepted but produce
  // no descriptor, so they yield no result transactions.
  cbe_pkg::push_t wr;
  cbe_pkg::desc_t q_head;
  logic           q_empty;
  logic           q_pop;

  cbe_front u_front (
    .in_push    (in_push),
    .in_command (in_command),
    .in_value   (in_value),
    .wr         (wr)
  );

  // The queue decouples classification from serialization, so that a new
  // command can enter while a long head is still being sent.
  cbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .pop   (q_pop),
    .full  (in_full),
    .empty (q_empty),
    .head  (q_head)
  );

  // The serializer holds the byte on offer in its output register and loads
  // the next one in the same cycle that the current one is popped.
  cbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

`ifndef SYNTHESIS
  a_reset_empties_output: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result present right after reset");
`endif

endmodule

// ----- test/cbe_checker.sv -----
// Scoreboard for the CBOR head encoder: predicts the byte stream and compares it.
`timescale 1ns / 1ps

module cbe_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [3:0]  in_command,
  input  logic [63:0] in_value,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  output int          fail_count,
  output int          bytes_pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cbor_byte_t;

  cbor_byte_t encoded_bytes[$];

  function automatic void add_byte(input logic [7:0] data, input logic last);
    cbor_byte_t entry;
    entry.data = data;
    entry.last = last;
    encoded_bytes.push_back(entry);
  endfunction

  // Shortest head: immediate argument below 24, else 1, 2, 4 or 8 argument bytes.
  function automatic void add_head(input logic [2:0] major, input logic [63:0] arg);
    logic [4:0] info;
    int         nbytes;
    if (arg < 64'd24) begin
      add_byte({major, arg[4:0]}, 1'b1);
      return;
    end
    if (arg < 64'd256) begin
      info   = cbe_pkg::AI_ARG1;
      nbytes = 1;
    end else if (arg < 64'd65536) begin
      info   = cbe_pkg::AI_ARG2;
      nbytes = 2;
    end else if (arg < 64'h1_0000_0000) begin
      info   = cbe_pkg::AI_ARG4;
      nbytes = 4;
    end else begin
      info   = cbe_pkg::AI_ARG8;
      nbytes = 8;
    end
    add_byte({major, info}, 1'b0);
    for (int i = nbytes - 1; i >= 0; i--) begin
      add_byte(arg[8*i +: 8], i == 0);
    end
  endfunction

  function automatic void encode_command(input logic [3:0] command, input logic [63:0] value);
    case (command)
      cbe_pkg::CMD_UINT: add_head(cbe_pkg::MAJ_UINT, value);
      cbe_pkg::CMD_SINT: begin
        if (value[63]) begin
          add_head(cbe_pkg::MAJ_NINT, ~value);
        end else begin
          add_head(cbe_pkg::MAJ_UINT, value);
        end
      end
      // For these commands the code equals the major type.
      cbe_pkg::CMD_BYTES, cbe_pkg::CMD_TEXT, cbe_pkg::CMD_ARRAY,
      cbe_pkg::CMD_MAP, cbe_pkg::CMD_TAG, cbe_pkg::CMD_SIMPLE: begin
        add_head(command[2:0], value);
      end
      cbe_pkg::CMD_BOOL:
        add_byte(value[0] ? cbe_pkg::BYTE_TRUE : cbe_pkg::BYTE_FALSE, 1'b1);
      cbe_pkg::CMD_NULL:    add_byte(cbe_pkg::BYTE_NULL, 1'b1);
      cbe_pkg::CMD_UNDEF:   add_byte(cbe_pkg::BYTE_UNDEF, 1'b1);
      cbe_pkg::CMD_PAYLOAD: add_byte(value[7:0], 1'b1);
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    cbor_byte_t want;
    if (!rst_n) begin
      fail_count = 0;
      encoded_bytes.delete();
    end else begin
      // A byte popped at this edge can only stem from an earlier command.
      if (out_pop && !out_empty) begin
        if (encoded_bytes.size() == 0) begin
          if (fail_count < 10) begin
            $display("[%0t] unexpected byte %02h last %b", $realtime, out_byte, out_last);
          end
          fail_count = fail_count + 1;
        end else begin
          want = encoded_bytes.pop_front();
          if (out_byte !== want.data || out_last !== want.last) begin
            if (fail_count < 10) begin
              $display("[%0t] byte mismatch: expected %02h last %b, got %02h last %b",
                       $realtime, want.data, want.last, out_byte, out_last);
            end
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_push && !in_full) begin
        encode_command(in_command, in_value);
      end
    end
    bytes_pending = encoded_bytes.size();
  end

endmodule

// ----- test/tb_top.sv -----
// Top of the CBOR head encoder testbench: stimulus, result-side stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

  // Every input of the encoder starts at a known value.
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_push    = 1'b0;
  logic [3:0]  in_command = 4'd0;
  logic [63:0] in_value   = 64'd0;
  logic        out_pop    = 1'b0;
  logic        in_full;
  logic        out_empty;
  logic [7:0]  out_byte;
  logic        out_last;

  int          fail_count;
  int          bytes_pending;
  logic [7:0]  pop_phase = 8'd0;

  cbor_head_encoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_command(in_command),
    .in_value  (in_value),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  cbe_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_command   (in_command),
    .in_value     (in_value),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .bytes_pending(bytes_pending)
  );

  // A 2 ns clock period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The result side cycles through four stall patterns: a steady
  // pop, a coin flip, long stalls that let the queue fill and push back on the
  // sender, and a mostly steady pop with a stall now and then.
  always @(negedge clk) begin
    pop_phase <= pop_phase + 8'd1;
    case (pop_phase[7:6])
      2'd0: out_pop <= 1'b1;
      2'd1: out_pop <= ($urandom_range(0, 1) == 0);
      2'd2: out_pop <= (pop_phase[2:0] == 3'd0);
      default: out_pop <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Offers one command from the falling edge on and holds it until a rising edge
  // takes it. The full flag is read at the falling edge, where it already holds the
  // value that the next rising edge will see.
  task automatic push_command(input logic [3:0] command, input logic [63:0] value);
    logic taken;
    @(negedge clk);
    in_push    = 1'b1;
    in_command = command;
    in_value   = value;
    taken      = 1'b0;
    while (!taken) begin
      taken = !in_full;
      @(posedge clk);
      if (!taken) begin
        @(negedge clk);
      end
    end
  endtask

  // Leaves the input idle for a number of cycles with junk on the payload ports,
  // which must be ignored while push is low.
  task automatic idle_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_push    = 1'b0;
      in_command = 4'($urandom);
      in_value   = {$urandom, $urandom};
    end
  endtask

  // Holds the sender back until every predicted byte has been popped.
  task automatic wait_drained();
    @(negedge clk);
    in_push = 1'b0;
    while (bytes_pending != 0) begin
      @(negedge clk);
    end
  endtask

  // Picks an argument from one of the size classes of the shortest-head rule,
  // or a boundary value of a class, or a full random 64-bit word.
  function automatic logic [63:0] random_argument();
    logic [63:0] word;
    word = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 23));
      1: return 64'($urandom_range(24, 255));
      2: return 64'($urandom_range(256, 65535));
      3: return {32'd0, word[31:0] | 32'h0001_0000};
      4: return word;
      default: begin
        case ($urandom_range(0, 8))
          0: return 64'd23;
          1: return 64'd24;
          2: return 64'd255;
          3: return 64'd256;
          4: return 64'd65535;
          5: return 64'd65536;
          6: return 64'hffff_ffff;
          7: return 64'h1_0000_0000;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  initial begin
    int          sent;
    int          burst_left;
    logic [3:0]  command;
    logic [63:0] value;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: every head size of unsigned integers at its boundaries, each other major type, the
    // sign split of signed integers, and the fixed-byte and pass-through commands.
    push_command(cbe_pkg::CMD_UINT, 64'd0);
    push_command(cbe_pkg::CMD_UINT, 64'd23);
    push_command(cbe_pkg::CMD_UINT, 64'd24);
    push_command(cbe_pkg::CMD_UINT, 64'd255);
    push_command(cbe_pkg::CMD_UINT, 64'd256);
    push_command(cbe_pkg::CMD_UINT, 64'd65535);
    push_command(cbe_pkg::CMD_UINT, 64'd65536);
    push_command(cbe_pkg::CMD_UINT, 64'hffff_ffff);
    push_command(cbe_pkg::CMD_UINT, 64'h1_0000_0000);
    push_command(cbe_pkg::CMD_UINT, '1);
    // Minus one encodes as negative zero; the most negative value takes eight argument bytes.
    push_command(cbe_pkg::CMD_SINT, '1);
    push_command(cbe_pkg::CMD_SINT, 64'h8000_0000_0000_0000);
    push_command(cbe_pkg::CMD_SINT, -64'sd25);
    // A non-negative signed integer is encoded exactly like an unsigned one.
    push_command(cbe_pkg::CMD_SINT, 64'd100);
    push_command(cbe_pkg::CMD_BYTES, 64'd5);
    push_command(cbe_pkg::CMD_TEXT, 64'd300);
    push_command(cbe_pkg::CMD_ARRAY, 64'd70000);
    push_command(cbe_pkg::CMD_MAP, 64'd0);
    push_command(cbe_pkg::CMD_TAG, 64'h100_0000_0000);
    // Simple values get no range check, so 255 takes a one-byte argument.
    push_command(cbe_pkg::CMD_SIMPLE, 64'd255);
    push_command(cbe_pkg::CMD_SIMPLE, 64'h7fff_ffff_ffff_ffff);
    // Only bit 0 of a boolean counts, and only the low byte of a payload command.
    push_command(cbe_pkg::CMD_BOOL, 64'hffff_ffff_ffff_fffe);
    push_command(cbe_pkg::CMD_BOOL, 64'd1);
    push_command(cbe_pkg::CMD_NULL, '1);
    push_command(cbe_pkg::CMD_UNDEF, 64'd0);
    push_command(cbe_pkg::CMD_PAYLOAD, 64'hdead_beef_cafe_f00d);
    // Unused command codes produce nothing.
    push_command(4'd12, 64'd5);
    push_command(4'd15, '1);

    // Random part: bursts of back-to-back commands separated by random gaps.
    sent       = 0;
    burst_left = 0;
    while (sent < 100) begin
      if (burst_left == 0) begin
        idle_input($urandom_range(1, 6));
        burst_left = $urandom_range(1, 12);
      end
      if ($urandom_range(0, 99) < 4) begin
        command = 4'($urandom_range(12, 15));
      end else begin
        command = 4'($urandom_range(0, 11));
        sent++;
      end
      value = random_argument();
      if (command == cbe_pkg::CMD_SINT && $urandom_range(0, 1) == 1) begin
        value = ~value;
      end
      push_command(command, value);
      burst_left--;
      // Halfway through, let everything drain before resuming.
      if (sent == 50) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: a correct run takes well under a tenth of this.
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule
